// ===== src/periodic_timer_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_defines.svh
// Assertion macros for the timer scheduler.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_SCHEDULER_DEFINES_SVH
`define PERIODIC_TIMER_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain property checked on every clock outside reset.
`define PTS_CHECK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("check failed: lbl");
// Same-cycle implication.
`define PTS_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("check failed: lbl");
`else
`define PTS_CHECK(lbl, clk_s, rstn_s, prop)
`define PTS_IMPLIES(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

// ===== src/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// Types and constants shared by the periodic timer scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int TW        = 32;                    // time width
  localparam int SW        = $clog2(NUM_SLOTS);     // slot index width
  localparam int CW        = $clog2(NUM_SLOTS + 1); // scan counter width
  localparam int RW        = 5;                     // sink room width
  localparam int MW        = 16;                    // margin width
  localparam int DIVCW     = $clog2(TW);

  localparam logic [MW-1:0] DUE_MARGIN_RESET = MW'(100);
  localparam logic [TW-1:0] THALF = {1'b1, {(TW-1){1'b0}}};

  localparam int IN_DW  = 112;
  localparam int OUT_DW = 40;

  typedef enum logic [1:0] {
    MODE_ARM   = 2'd0,
    MODE_ABORT = 2'd1,
    MODE_MOVE  = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_FIRE = 1'b0,
    KIND_WAKE = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPWR,
    ST_SCAN,
    ST_FDEC,
    ST_PUSH,
    ST_RLRD,
    ST_RLSET,
    ST_DIV,
    ST_MUL,
    ST_RLWR,
    ST_WDEC,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    kind_t           kind;
    logic [SW-1:0]   slot;
    logic [TW-1:0]   tval;
  } result_t;

endpackage

`default_nettype wire

// ===== src/periodic_timer_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_scheduler
// Timer slots in block RAM; fires due slots earliest first, reloads periodic
// slots in closed form and reports the next wake-up time.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents
// in_*    | in  | tdata: mode, slot_index, deadline, period, now, sink_room
// out_*   | out | tuser: kind; tdata: fired_slot, time_value; tlast: last
// cfg_*   | in  | wr_data: due_margin
//
// One item at a time. A slot scan reads every slot through the RAM read port,
// then a decision state acts on the earliest slot found. A fire passes a push
// state; a periodic reload runs a 32-step divider, multiply and write back,
// while a one-shot slot is cleared. An abort fires no slot. Output stalls
// hold the push and flush states. Reset clears the active bits; RAMs need
// none.
// ----------------------------------------------------------------------------
`default_nettype none
`include "periodic_timer_scheduler_defines.svh"

module periodic_timer_scheduler (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  // mode[1:0] slot_index[5:2] deadline[37:6] period[69:38] now[101:70]
  // sink_room[106:102], zero fill above
  input  wire [pts_pkg::IN_DW-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  wire                       out_tready,
  // fired_slot[3:0] time_value[35:4], zero fill above
  output logic [pts_pkg::OUT_DW-1:0] out_tdata,
  // kind[0]
  output logic                      out_tuser,
  output logic                      out_tlast,
  input  wire                       cfg_wr_en,
  input  wire [15:0]                cfg_wr_data
);
  import pts_pkg::*;

  // slot storage
  logic [TW-1:0] dl_mem  [NUM_SLOTS];
  logic [TW-1:0] per_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] act_r;

  state_t state_r, state_nxt;

  logic [MW-1:0] margin_r;
  mode_t         mode_r;
  logic [SW-1:0] idx_r;
  logic [TW-1:0] in_dl_r, in_per_r, now_r, t_r;
  logic [RW-1:0] room_r, n_r;

  logic [CW-1:0] sc_r;
  logic          wake_scan_r;
  logic          best_v_r;
  logic [SW-1:0] best_idx_r;
  logic [TW-1:0] best_key_r, best_dl_r;

  logic [TW-1:0] rd_dl_r, rd_per_r;
  logic [SW-1:0] rd_addr;

  result_t       new_r, pend_r;
  logic          pend_v_r, push_wake_r;

  logic [TW-1:0] sv_dl_r, sv_per_r, den_r, quo_r, prod_r;
  logic [TW:0]   rem_r;
  logic          case_a_r;
  logic [DIVCW-1:0] div_cnt_r;

  logic          out_valid_r, out_last_r;
  result_t       out_res_r;

  logic          out_free, out_load;
  logic          dl_we, per_we;
  logic [SW-1:0] dl_wa;
  logic [TW-1:0] dl_wd;

  // scan evaluation
  logic [SW-1:0] ev_idx;
  logic [TW-1:0] ev_key;
  logic          ev_cand;
  logic [TW-1:0] x_c, negp_c, k_c;
  logic [TW:0]   rem_sh;
  logic          div_ge;

  assign out_free = !out_valid_r || out_tready;
  assign out_load = (state_r == ST_PUSH || state_r == ST_FLUSH) && pend_v_r && out_free;

  assign ev_idx = SW'(sc_r - CW'(1));
  always_comb begin
    if (wake_scan_r) begin
      ev_key  = rd_dl_r - now_r + THALF;
      ev_cand = act_r[ev_idx];
    end else begin
      ev_key  = rd_dl_r - t_r;
      ev_cand = act_r[ev_idx] && ev_key[TW-1];
    end
  end

  assign x_c    = rd_dl_r - t_r;
  assign negp_c = TW'(0) - rd_per_r;
  assign rem_sh = {rem_r[TW-1:0], quo_r[TW-1]};
  assign div_ge = rem_sh >= {1'b0, den_r};
  assign k_c    = quo_r + (case_a_r ? TW'(rem_r != '0) : TW'(1));

  assign rd_addr = (state_r == ST_SCAN) ? sc_r[SW-1:0] : best_idx_r;

  // RAM write port control
  always_comb begin
    dl_we  = 1'b0;
    per_we = 1'b0;
    dl_wa  = idx_r;
    dl_wd  = in_dl_r;
    if (state_r == ST_OPWR) begin
      dl_we  = (mode_r == MODE_ARM) || (mode_r == MODE_MOVE);
      per_we = (mode_r == MODE_ARM);
    end else if (state_r == ST_RLWR) begin
      dl_we = 1'b1;
      dl_wa = best_idx_r;
      dl_wd = sv_dl_r + prod_r;
    end
  end

  // slot RAMs, registered read
  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    if (per_we) per_mem[idx_r] <= in_per_r;
    rd_dl_r  <= dl_mem[rd_addr];
    rd_per_r <= per_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_OPWR;
      ST_OPWR:  state_nxt = ST_SCAN;
      ST_SCAN:  if (sc_r == CW'(NUM_SLOTS)) state_nxt = wake_scan_r ? ST_WDEC : ST_FDEC;
      ST_FDEC:  state_nxt = (best_v_r && n_r < room_r) ? ST_PUSH : ST_SCAN;
      ST_PUSH:  if (!pend_v_r || out_free) state_nxt = push_wake_r ? ST_FLUSH : ST_RLRD;
      ST_RLRD:  state_nxt = ST_RLSET;
      ST_RLSET: state_nxt = (rd_per_r == '0) ? ST_SCAN : ST_DIV;
      ST_DIV:   if (div_cnt_r == DIVCW'(TW-1)) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_RLWR;
      ST_RLWR:  state_nxt = ST_SCAN;
      ST_WDEC:  state_nxt = best_v_r ? ST_PUSH : ST_FLUSH;
      ST_FLUSH: if (!pend_v_r || out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    out_tuser  = out_res_r.kind;
    out_tdata  = {{(OUT_DW-TW-SW){1'b0}}, out_res_r.tval, out_res_r.slot};
    out_tlast  = out_last_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      act_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      margin_r    <= DUE_MARGIN_RESET;
      n_r         <= '0;
      room_r      <= '0;
      best_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) margin_r <= cfg_wr_data;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          room_r <= in_tdata[106:102];
          n_r    <= '0;
        end
        ST_OPWR: begin
          if (mode_r == MODE_ABORT) act_r[idx_r] <= 1'b0;
          else if (mode_r != MODE_TICK) act_r[idx_r] <= 1'b1;
          best_v_r <= 1'b0;
        end
        ST_SCAN: if (sc_r != '0 && ev_cand && (!best_v_r || ev_key < best_key_r)) begin
          best_v_r <= 1'b1;
        end
        ST_FDEC: begin
          if (best_v_r && n_r < room_r) n_r <= n_r + RW'(1);
          else best_v_r <= 1'b0;
        end
        ST_PUSH: if (!pend_v_r || out_free) pend_v_r <= 1'b1;
        ST_RLSET: if (rd_per_r == '0) begin
          act_r[best_idx_r] <= 1'b0;
          best_v_r <= 1'b0;
        end
        ST_RLWR: best_v_r <= 1'b0;
        ST_FLUSH: if (out_free) pend_v_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r  <= pend_r;
      out_last_r <= (state_r == ST_FLUSH);
    end
    case (state_r)
      ST_IDLE: begin
        mode_r   <= mode_t'(in_tdata[1:0]);
        idx_r    <= in_tdata[5:2];
        in_dl_r  <= in_tdata[37:6];
        in_per_r <= in_tdata[69:38];
        now_r    <= in_tdata[101:70];
        t_r      <= in_tdata[101:70] + TW'(margin_r);
      end
      ST_OPWR: begin
        sc_r        <= '0;
        wake_scan_r <= (mode_r == MODE_ABORT);
      end
      ST_SCAN: begin
        sc_r <= sc_r + CW'(1);
        if (sc_r != '0 && ev_cand && (!best_v_r || ev_key < best_key_r)) begin
          best_idx_r <= ev_idx;
          best_key_r <= ev_key;
          best_dl_r  <= rd_dl_r;
        end
      end
      ST_FDEC: begin
        if (best_v_r && n_r < room_r) begin
          new_r       <= '{kind: KIND_FIRE, slot: best_idx_r, tval: now_r};
          push_wake_r <= 1'b0;
        end else begin
          sc_r        <= '0;
          wake_scan_r <= 1'b1;
        end
      end
      ST_PUSH: if (!pend_v_r || out_free) pend_r <= new_r;
      ST_RLSET: begin
        sc_r     <= '0;
        sv_dl_r  <= rd_dl_r;
        sv_per_r <= rd_per_r;
        case_a_r <= !rd_per_r[TW-1];
        rem_r    <= '0;
        div_cnt_r <= '0;
        if (!rd_per_r[TW-1]) begin
          quo_r <= TW'(0) - x_c;
          den_r <= rd_per_r;
        end else begin
          quo_r <= x_c - THALF;
          den_r <= (negp_c == '0) ? THALF : negp_c;
        end
      end
      ST_DIV: begin
        div_cnt_r <= div_cnt_r + DIVCW'(1);
        quo_r     <= {quo_r[TW-2:0], div_ge};
        rem_r     <= div_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      end
      ST_MUL: prod_r <= TW'(k_c * sv_per_r);
      ST_RLWR: sc_r <= '0;
      ST_WDEC: if (best_v_r) begin
        new_r <= '{kind: KIND_WAKE, slot: '0,
                   tval: ((now_r - best_dl_r) >> (TW-1)) != '0 ? best_dl_r : t_r};
        push_wake_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // checks
  `PTS_CHECK(a_room_bound, clk, rst_n, n_r <= room_r)
  `PTS_IMPLIES(a_tail_held, clk, rst_n, out_valid_r && !out_last_r, pend_v_r)
  `PTS_IMPLIES(a_idle_empty, clk, rst_n, in_tready, !pend_v_r)

endmodule

`default_nettype wire

// ===== tb/periodic_timer_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_test
// Self-checking bench: drives arm/abort/move/tick beats, predicts fire and
// wake-up beats with a behavioral slot table, and compares them in order.
// ----------------------------------------------------------------------------
module periodic_timer_scheduler_test;
  import pts_pkg::*;

  localparam int MAX_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  periodic_timer_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic [TW-1:0] dl_tab [NUM_SLOTS];
  logic [TW-1:0] per_tab [NUM_SLOTS];
  logic act_tab [NUM_SLOTS];
  logic ever_armed [NUM_SLOTS];
  logic [MW-1:0] margin;

  result_t exp_beats [$];
  logic exp_last [$];
  logic [IN_DW-1:0] pending_beats [$];
  int idle_pct_in = 0, idle_pct_out = 0;
  int errors = 0;
  int cycles = 0;

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("periodic_timer_scheduler_test: FAIL");
      $finish;
    end
  end

  function automatic logic is_older(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [TW-1:0] d;
    d = a - b;
    return d[TW-1];
  endfunction

  // advance deadline by whole periods until it no longer precedes t
  function automatic logic [TW-1:0] reload_deadline(logic [TW-1:0] d, logic [TW-1:0] p,
                                                   logic [TW-1:0] t);
    logic [TW-1:0] x, n, q;
    logic [63:0] k;
    x = d - t;
    if (!p[TW-1]) begin
      n = -x;
      k = n / p + ((n % p) != 0 ? 1 : 0);
    end else begin
      q = -p;
      if (q == 0) q = THALF;
      k = (x - THALF) / q + 1;
    end
    return d + TW'(k * p);
  endfunction

  task automatic predict_item(logic [IN_DW-1:0] beat);
    mode_t md;
    logic [3:0] idx;
    logic [TW-1:0] dl, per, now, t, key, bkey, wake;
    int room, n, best;
    md = mode_t'(beat[1:0]);
    idx = beat[5:2];
    dl = beat[37:6];
    per = beat[69:38];
    now = beat[101:70];
    room = int'(beat[106:102]);
    t = now + TW'(margin);
    n = 0;
    case (md)
      MODE_ARM: begin
        dl_tab[idx] = dl; per_tab[idx] = per; act_tab[idx] = 1'b1; ever_armed[idx] = 1'b1;
      end
      MODE_ABORT: act_tab[idx] = 1'b0;
      MODE_MOVE: begin
        dl_tab[idx] = dl; act_tab[idx] = 1'b1;
      end
      default: ;
    endcase
    if (md != MODE_ABORT) begin
      while (n < room) begin
        best = -1; bkey = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!act_tab[i] || !is_older(dl_tab[i], t)) continue;
          key = dl_tab[i] - t;
          if (best < 0 || key < bkey) begin best = i; bkey = key; end
        end
        if (best < 0) break;
        exp_beats.push_back('{KIND_FIRE, SW'(best), now});
        exp_last.push_back(1'b0);
        n++;
        if (per_tab[best] == 0) act_tab[best] = 1'b0;
        else dl_tab[best] = reload_deadline(dl_tab[best], per_tab[best], t);
      end
    end
    best = -1; bkey = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!act_tab[i]) continue;
      key = dl_tab[i] - now + THALF;
      if (best < 0 || key < bkey) begin best = i; bkey = key; end
    end
    if (best >= 0) begin
      wake = is_older(now, dl_tab[best]) ? dl_tab[best] : t;
      exp_beats.push_back('{KIND_WAKE, '0, wake});
      exp_last.push_back(1'b0);
      n++;
    end
    if (n > 0) exp_last[$] = 1'b1;
  endtask

  function automatic logic [IN_DW-1:0] pack_item(mode_t md, logic [3:0] idx,
      logic [TW-1:0] dl, logic [TW-1:0] per, logic [TW-1:0] now, logic [4:0] room);
    return {5'd0, room, now, per, dl, idx, md};
  endfunction

  // driver: predicts at acceptance so state matches the block's order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_item(in_tdata);
      if (!in_tvalid || in_tready) begin
        if ((in_tvalid && in_tready ? pending_beats.size() > 1 : pending_beats.size() > 0)
            && $urandom_range(99) >= idle_pct_in) begin
          if (in_tvalid && in_tready) void'(pending_beats.pop_front());
          in_tvalid <= 1'b1;
          in_tdata <= pending_beats[0];
        end else begin
          if (in_tvalid && in_tready) void'(pending_beats.pop_front());
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor / checker
  always @(posedge clk) begin
    result_t e;
    logic el;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= idle_pct_out);
      if (out_tvalid && out_tready) begin
        if (exp_beats.size() == 0) begin
          $error("unexpected beat kind=%0d slot=%0d time=%0h",
                 out_tuser, out_tdata[3:0], out_tdata[35:4]);
          errors++;
        end else begin
          e = exp_beats.pop_front();
          el = exp_last.pop_front();
          if (out_tuser !== e.kind) begin
            $error("kind exp %0d act %0d", e.kind, out_tuser); errors++;
          end
          if (out_tdata[3:0] !== e.slot) begin
            $error("fired_slot exp %0d act %0d", e.slot, out_tdata[3:0]); errors++;
          end
          if (out_tdata[35:4] !== e.tval) begin
            $error("time_value exp %0h act %0h", e.tval, out_tdata[35:4]); errors++;
          end
          if (out_tlast !== el) begin
            $error("last exp %0d act %0d", el, out_tlast); errors++;
          end
        end
      end
    end
  end

  // wait until every queued beat is taken and every result has arrived
  task automatic drain();
    while (pending_beats.size() > 0 || in_tvalid) @(posedge clk);
    repeat (2) @(posedge clk);
    while (exp_beats.size() > 0) @(posedge clk);
    // items with no result may still be busy
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_margin(logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    margin = v;
  endtask

  // random item; moves only reach slots that were armed at some point
  function automatic logic [IN_DW-1:0] rand_item(logic [TW-1:0] base);
    mode_t md;
    logic [3:0] idx;
    logic [TW-1:0] dl, per;
    int r;
    r = $urandom_range(99);
    md = r < 40 ? MODE_ARM : r < 55 ? MODE_ABORT : r < 70 ? MODE_MOVE : MODE_TICK;
    idx = 4'($urandom_range(15));
    if (md == MODE_MOVE && !ever_armed[idx]) md = MODE_ARM;
    if (md == MODE_ARM) ever_armed[idx] = 1'b1;
    dl = ($urandom_range(9) == 0) ? $urandom : base + $urandom_range(3000) - 1000;
    r = $urandom_range(9);
    per = r < 3 ? '0 : r < 8 ? TW'($urandom_range(1, 800)) : $urandom;
    return pack_item(md, idx, dl, per, base, ($urandom_range(5) == 0) ?
                     5'($urandom_range(16)) : 5'd16);
  endfunction

  initial begin
    logic [TW-1:0] now_t;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      act_tab[i] = 1'b0; ever_armed[i] = 1'b0; dl_tab[i] = '0; per_tab[i] = '0;
    end
    margin = DUE_MARGIN_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every mode, ignored slot, full sink, wrap
    pending_beats.push_back(pack_item(MODE_TICK, 4'd0, '0, '0, '0, 5'd16));
    pending_beats.push_back(pack_item(MODE_ARM, 4'd0, 32'd50, 32'd0, 32'd0, 5'd16));
    pending_beats.push_back(pack_item(MODE_ARM, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FF00, 5'd16));
    pending_beats.push_back(pack_item(MODE_ARM, 4'd3, 32'd500, 32'd10, 32'd0, 5'd0));
    pending_beats.push_back(pack_item(MODE_ARM, 4'd4, 32'd500, 32'h8000_0000, 32'd0, 5'd1));
    pending_beats.push_back(pack_item(MODE_ARM, 4'd3, 32'd1000, 32'd7, 32'd900, 5'd16));
    pending_beats.push_back(pack_item(MODE_MOVE, 4'd0, 32'd2000, '0, 32'd900, 5'd16));
    pending_beats.push_back(pack_item(MODE_ABORT, 4'd3, '0, '0, 32'd5000, 5'd16));
    pending_beats.push_back(pack_item(MODE_TICK, 4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'd5000, 5'd2));
    for (int i = 0; i < NUM_SLOTS; i++)
      pending_beats.push_back(pack_item(MODE_ARM, 4'(i), 32'h7FFF_FFF0, 32'd3,
                                        32'h7FFF_FF00, 5'd0));
    pending_beats.push_back(pack_item(MODE_TICK, 4'd0, '0, '0, 32'h8000_0010, 5'd16));
    pending_beats.push_back(pack_item(MODE_TICK, 4'd0, '0, '0, 32'h8000_0100, 5'd31));
    for (int i = 0; i < NUM_SLOTS; i++) ever_armed[i] = 1'b1;
    drain();

    now_t = 32'h8000_1000;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct_in = 0;  idle_pct_out = 0;  write_margin(16'd0); end
        1: begin idle_pct_in = 58; idle_pct_out = 0;  write_margin(16'hFFFF); end
        2: begin idle_pct_in = 0;  idle_pct_out = 58; write_margin(16'd100); end
        3: begin idle_pct_in = 20; idle_pct_out = 20; write_margin(16'($urandom)); end
        default: begin idle_pct_in = 0; idle_pct_out = 0; write_margin(16'd37); end
      endcase
      for (int k = 0; k < 15; k++) begin
        now_t += $urandom_range(400);
        if ($urandom_range(30) == 0) now_t = $urandom;
        pending_beats.push_back(rand_item(now_t));
        // once, hold off until every result is in
        if (ph == 3 && k == 10) begin
          while (pending_beats.size() > 0 || in_tvalid) @(posedge clk);
          repeat (2) @(posedge clk);
          while (exp_beats.size() > 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0)
      $display("periodic_timer_scheduler_test: PASS");
    else
      $display("periodic_timer_scheduler_test: FAIL");
    $finish;
  end
endmodule
